@@ hw/rtl/crsfr_pkg.sv @@
// Shared types, constants and CRC helper for the frame receiver.
`timescale 1ns / 1ps
package crsfr_pkg;

  localparam int MaxPacketDef = 64;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] MIN_LEN = 8'd3;

  typedef enum logic [2:0] {
    EV_PASS      = 3'd0,
    EV_DISCARD   = 3'd1,
    EV_GOOD      = 3'd2,
    EV_LINK_UP   = 3'd3,
    EV_LINK_DOWN = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    REG_PASSTHROUGH = 3'd0,
    REG_PKT_TIMEOUT = 3'd1,
    REG_LINK_DOWN   = 3'd2,
    REG_ACCEPT_ADDR = 3'd3,
    REG_CHAN_TYPE   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] byte_value;
    logic [7:0] frame_address;
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       shift;
    logic       wr;
    logic [7:0] wr_data;
  } cell_ctl_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/crsfr_if.sv @@
// Item channel interfaces for the frame receiver.
`timescale 1ns / 1ps
interface crsfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface crsfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] byte_value;
  logic [7:0] frame_address;
  logic [7:0] frame_type;
  logic [5:0] frame_length;
  logic       last;
  modport source (output valid, output event_res, output byte_value, output frame_address,
                  output frame_type, output frame_length, output last, input ready);
  modport sink (input valid, input event_res, input byte_value, input frame_address,
                input frame_type, input frame_length, input last, output ready);
endinterface

@@ hw/rtl/crsfr_cell.sv @@
// One byte cell of the frame buffer chain.
`timescale 1ns / 1ps
module crsfr_cell (
  input  logic                  clk,
  input  crsfr_pkg::cell_ctl_t  ctl,
  input  logic                  sel,
  input  logic [7:0]            nbr,
  output logic [7:0]            q
);
  import crsfr_pkg::*;

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      data_r <= ctl.wr_data;
    end else if (ctl.shift) begin
      data_r <= nbr;
    end
  end

  assign q = data_r;

endmodule

@@ hw/rtl/crsf_frame_receiver_unit.sv @@
// Top level: frame receiver with a rotating chain of byte cells.
// A byte passes S_IDLE, S_PARSE and S_FINISH (S_IDLE and S_FINISH in passthrough); a
// complete frame adds S_CRC and S_VERDICT, and S_GOOD when accepted; a resync drop stays in S_PARSE.
// A tick passes S_IDLE, then S_FLUSH when the buffer times out, then S_LINK and S_FINISH.
// One item is in work at a time, and output stalls hold it. Results leave through a
// one-deep hold plus an output register. Sync active-low reset clears state, config to defaults.
`timescale 1ns / 1ps
module crsf_frame_receiver_unit #(
  parameter int MAX_PACKET = crsfr_pkg::MaxPacketDef
) (
  input  logic              clk,
  input  logic              rst_n,
  crsfr_in_if.sink          in_ch,
  crsfr_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import crsfr_pkg::*;

  localparam int FW = $clog2(MAX_PACKET + 1);
  localparam int IW = $clog2(MAX_PACKET);
  localparam logic [8:0] MAX_LEN = 9'(MAX_PACKET - 2);
  localparam logic [FW-1:0] FULL = FW'(MAX_PACKET);

  typedef enum logic [2:0] {
    S_IDLE, S_PARSE, S_CRC, S_VERDICT, S_GOOD, S_FLUSH, S_LINK, S_FINISH
  } state_t;

  state_t          state_r;
  logic [FW-1:0]   fill_r;
  logic [15:0]     idle_r;
  logic            link_r;
  logic            pass_r;
  logic [15:0]     pto_r;
  logic [15:0]     ldt_r;
  logic [7:0]      acc_r;
  logic [7:0]      chan_r;
  logic [7:0]      len_r;
  logic [7:0]      addr_r;
  logic [7:0]      typ_r;
  logic [7:0]      crc_r;
  logic            crc_ok_r;
  logic [FW-1:0]   k_r;
  res_t            out_r;
  logic            out_valid_r;
  res_t            pend_r;
  logic            pend_v_r;

  logic [7:0]      q [MAX_PACKET];
  cell_ctl_t       ctl;
  logic [15:0]     idle_nxt;
  logic            slot_ok;
  logic            in_acc;
  logic [7:0]      len_now;
  logic            len_bad;
  logic            frame_full;
  logic [8:0]      len_p2;
  logic [8:0]      k_ext;
  logic [8:0]      len_ext;
  logic            out_load;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PACKET; gi++) begin : g_cell
      localparam int NB = (gi + 1) % MAX_PACKET;
      crsfr_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .sel (fill_r[IW-1:0] == IW'(gi)),
        .nbr (q[NB]),
        .q   (q[gi])
      );
    end
  endgenerate

  assign slot_ok    = !out_valid_r || out_ch.ready;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign idle_nxt   = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign len_now    = q[1];
  assign len_bad    = (len_now < MIN_LEN) || ({1'b0, len_now} > MAX_LEN);
  assign len_p2     = {1'b0, len_now} + 9'd2;
  assign frame_full = (9'(fill_r) >= len_p2);
  assign k_ext      = 9'(k_r);
  assign len_ext    = {1'b0, len_r};

  always_comb begin
    ctl = '0;
    ctl.wr_data = in_ch.rx_byte;
    unique case (state_r)
      S_IDLE:  ctl.wr = in_acc && (in_ch.opcode == OP_BYTE) && !pass_r;
      S_PARSE: ctl.shift = (fill_r > FW'(1)) && len_bad && slot_ok;
      S_CRC:   ctl.shift = 1'b1;
      S_FLUSH: ctl.shift = (fill_r > FW'(1)) && slot_ok;
      default: ctl = '0;
    endcase
  end

  // held item moves to the output register
  always_comb begin
    out_load = 1'b0;
    unique case (state_r)
      S_PARSE:   out_load = (fill_r > FW'(1)) && len_bad;
      S_VERDICT: out_load = crc_ok_r && (addr_r == acc_r) && (typ_r == chan_r) && !link_r;
      S_GOOD:    out_load = 1'b1;
      S_FLUSH:   out_load = (fill_r > FW'(1));
      S_LINK:    out_load = link_r && (idle_r > ldt_r);
      S_FINISH:  out_load = 1'b1;
      default:   out_load = 1'b0;
    endcase
    out_load = out_load && slot_ok && pend_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idle_r      <= '0;
      link_r      <= 1'b0;
      pass_r      <= 1'b0;
      pto_r       <= 16'd100;
      ldt_r       <= 16'd300;
      acc_r       <= 8'd200;
      chan_r      <= 8'd22;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_r       <= '{pend_r.event_res, pend_r.byte_value, pend_r.frame_address,
                         pend_r.frame_type, pend_r.frame_length, (state_r == S_FINISH)};
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_PASSTHROUGH: pass_r <= cfg_wdata[0];
          REG_PKT_TIMEOUT: pto_r  <= cfg_wdata;
          REG_LINK_DOWN:   ldt_r  <= cfg_wdata;
          REG_ACCEPT_ADDR: acc_r  <= cfg_wdata[7:0];
          REG_CHAN_TYPE:   chan_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == OP_BYTE) begin
              idle_r <= '0;
              if (pass_r) begin
                pend_r   <= '{EV_PASS, in_ch.rx_byte, 8'd0, 8'd0, 6'd0, 1'b0};
                pend_v_r <= 1'b1;
                state_r  <= S_FINISH;
              end else begin
                fill_r  <= fill_r + FW'(1);
                state_r <= S_PARSE;
              end
            end else begin
              idle_r  <= idle_nxt;
              state_r <= ((fill_r != '0) && (idle_nxt > pto_r)) ? S_FLUSH : S_LINK;
            end
          end
        end
        S_PARSE: begin
          if (fill_r <= FW'(1)) begin
            state_r <= S_FINISH;
          end else if (len_bad) begin
            if (slot_ok) begin
              pend_r   <= '{EV_DISCARD, q[0], 8'd0, 8'd0, 6'd0, 1'b0};
              pend_v_r <= 1'b1;
              fill_r   <= fill_r - FW'(1);
            end
          end else if (frame_full) begin
            len_r   <= len_now;
            addr_r  <= q[0];
            typ_r   <= q[2];
            crc_r   <= '0;
            k_r     <= '0;
            state_r <= S_CRC;
          end else begin
            if (fill_r >= FULL) fill_r <= '0;
            state_r <= S_FINISH;
          end
        end
        S_CRC: begin
          k_r <= k_r + FW'(1);
          if (k_ext >= 9'd2 && k_ext <= len_ext) crc_r <= crc8_step(crc_r, q[0]);
          if (k_ext == len_ext + 9'd1) begin
            crc_ok_r <= (crc_r == q[0]);
            fill_r   <= fill_r - FW'(len_ext + 9'd2);
            state_r  <= S_VERDICT;
          end
        end
        S_VERDICT: begin
          if (!crc_ok_r || addr_r != acc_r) begin
            state_r <= S_PARSE;
          end else if (typ_r == chan_r && !link_r) begin
            if (slot_ok) begin
              pend_r   <= '{EV_LINK_UP, 8'd0, addr_r, typ_r, len_r[5:0], 1'b0};
              pend_v_r <= 1'b1;
              state_r  <= S_GOOD;
            end
          end else begin
            state_r <= S_GOOD;
          end
        end
        S_GOOD: begin
          if (slot_ok) begin
            pend_r   <= '{EV_GOOD, 8'd0, addr_r, typ_r, len_r[5:0], 1'b0};
            pend_v_r <= 1'b1;
            if (typ_r == chan_r) link_r <= 1'b1;
            state_r  <= S_PARSE;
          end
        end
        S_FLUSH: begin
          if (fill_r <= FW'(1)) begin
            fill_r  <= '0;
            state_r <= S_LINK;
          end else if (slot_ok) begin
            pend_r   <= '{EV_DISCARD, q[0], 8'd0, 8'd0, 6'd0, 1'b0};
            pend_v_r <= 1'b1;
            fill_r   <= fill_r - FW'(1);
          end
        end
        S_LINK: begin
          if (link_r && idle_r > ldt_r) begin
            if (slot_ok) begin
              pend_r   <= '{EV_LINK_DOWN, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0};
              pend_v_r <= 1'b1;
              link_r   <= 1'b0;
              state_r  <= S_FINISH;
            end
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (slot_ok) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = out_r.event_res;
  assign out_ch.byte_value    = out_r.byte_value;
  assign out_ch.frame_address = out_r.frame_address;
  assign out_ch.frame_type    = out_r.frame_type;
  assign out_ch.frame_length  = out_r.frame_length;
  assign out_ch.last          = out_r.last;

endmodule

@@ tb/sv/crsfr_tb_if.sv @@
// Testbench-side channel interface wrappers are taken from the RTL; this file holds a clock/reset bundle.
`timescale 1ns / 1ps
interface crsfr_tb_clk_if;
  logic clk;
  logic rst_n;
endinterface

@@ tb/sv/tb_top.sv @@
// Random and directed test of the frame receiver against a cycle-free deframer predictor.
`timescale 1ns / 1ps
module tb_top;
  import crsfr_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  crsfr_tb_clk_if sys_if ();
  crsfr_in_if in_ch ();
  crsfr_out_if out_ch ();

  assign clk = sys_if.clk;
  assign rst_n = sys_if.rst_n;

  crsf_frame_receiver_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    sys_if.clk = 1'b0;
    #4;
    sys_if.clk = 1'b1;
    #4;
  end

  class deframer_board;
    logic [7:0] store [64];
    int fill;
    int idle;
    bit link_up;
    bit pass_mode;
    int pkt_to;
    int down_to;
    logic [7:0] acc_addr;
    logic [7:0] chan_type;
    res_t pending[$];
    bit bad;

    function void clear();
      fill = 0; idle = 0; link_up = 0; pass_mode = 0;
      pkt_to = 100; down_to = 300; acc_addr = 200; chan_type = 22;
    endfunction

    function void set_reg(reg_idx_t r, logic [15:0] v);
      case (r)
        REG_PASSTHROUGH: pass_mode = v[0];
        REG_PKT_TIMEOUT: pkt_to = int'(v);
        REG_LINK_DOWN: down_to = int'(v);
        REG_ACCEPT_ADDR: acc_addr = v[7:0];
        REG_CHAN_TYPE: chan_type = v[7:0];
        default: ;
      endcase
    endfunction

    function void push(event_t e, logic [7:0] b, logic [7:0] a, logic [7:0] t,
                       logic [5:0] l, inout res_t q[$]);
      res_t r;
      r.event_res = e; r.byte_value = b; r.frame_address = a;
      r.frame_type = t; r.frame_length = l; r.last = 1'b0;
      q.push_back(r);
    endfunction

    function void drop(int cnt, inout res_t q[$]);
      if (cnt >= fill) begin
        fill = 0;
        return;
      end
      if (cnt == 1) push(EV_DISCARD, store[0], 8'd0, 8'd0, 6'd0, q);
      fill -= cnt;
      for (int i = 0; i < fill; i++) store[i] = store[i + cnt];
    endfunction

    function logic [7:0] frame_crc(int len);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < len - 1; i++) begin
        c ^= store[2 + i];
        for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
      end
      return c;
    endfunction

    function void note_item(opcode_t op, logic [7:0] b);
      res_t q[$];
      int len;
      if (op == OP_BYTE) begin
        idle = 0;
        if (pass_mode) push(EV_PASS, b, 8'd0, 8'd0, 6'd0, q);
        else begin
          if (fill >= 64) fill = 0;
          store[fill] = b;
          fill++;
          while (fill > 1) begin
            len = int'(store[1]);
            if (len < 3 || len > 62) drop(1, q);
            else if (fill >= len + 2) begin
              if (frame_crc(len) == store[len + 1] && store[0] == acc_addr) begin
                if (store[2] == chan_type && !link_up)
                  push(EV_LINK_UP, 8'd0, store[0], store[2], 6'(len), q);
                if (store[2] == chan_type) link_up = 1;
                push(EV_GOOD, 8'd0, store[0], store[2], 6'(len), q);
              end
              drop(len + 2, q);
            end else break;
          end
          if (fill >= 64) fill = 0;
        end
      end else begin
        if (idle < 65535) idle++;
        if (fill > 0 && idle > pkt_to) while (fill > 0) drop(1, q);
        if (link_up && idle > down_to) begin
          push(EV_LINK_DOWN, 8'd0, 8'd0, 8'd0, 6'd0, q);
          link_up = 0;
        end
      end
      if (q.size() > 0) q[q.size() - 1].last = 1'b1;
      foreach (q[i]) pending.push_back(q[i]);
    endfunction

    function void check_result(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        $error("unexpected result event=%0d", got.event_res);
        bad = 1;
        return;
      end
      w = pending.pop_front();
      if (got.event_res !== w.event_res) begin
        $error("event_res exp %0d got %0d", w.event_res, got.event_res); bad = 1;
      end
      if (got.byte_value !== w.byte_value) begin
        $error("byte_value exp %0h got %0h", w.byte_value, got.byte_value); bad = 1;
      end
      if (got.frame_address !== w.frame_address) begin
        $error("frame_address exp %0h got %0h", w.frame_address, got.frame_address);
        bad = 1;
      end
      if (got.frame_type !== w.frame_type) begin
        $error("frame_type exp %0h got %0h", w.frame_type, got.frame_type); bad = 1;
      end
      if (got.frame_length !== w.frame_length) begin
        $error("frame_length exp %0d got %0d", w.frame_length, got.frame_length); bad = 1;
      end
      if (got.last !== w.last) begin
        $error("last exp %0b got %0b", w.last, got.last); bad = 1;
      end
    endfunction
  endclass

  deframer_board board;
  int send_idle_pct = 14;
  int recv_idle_pct = 74;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // receiver: random stall, plus an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({event_t'(out_ch.event_res), out_ch.byte_value,
                          out_ch.frame_address, out_ch.frame_type,
                          out_ch.frame_length, out_ch.last});
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("crsf_frame_receiver_unit test failed");
      $finish;
    end
  end

  task automatic send_item(opcode_t op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(op, b);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [7:0] crc_of(logic [7:0] d[$]);
    logic [7:0] c;
    c = 0;
    foreach (d[i]) begin
      c ^= d[i];
      for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

  // frame with random content; corrupt spoils the crc
  task automatic send_frame(logic [7:0] addr, logic [7:0] typ, int plen, bit corrupt);
    logic [7:0] body[$];
    logic [7:0] c;
    body.push_back(typ);
    for (int i = 0; i < plen; i++) body.push_back(8'($urandom_range(255)));
    c = crc_of(body);
    if (corrupt) c ^= 8'h01 << $urandom_range(7);
    send_item(OP_BYTE, addr);
    send_item(OP_BYTE, 8'(plen + 2));
    foreach (body[i]) send_item(OP_BYTE, body[i]);
    send_item(OP_BYTE, c);
  endtask

  task automatic random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(99));
      if (sel < 55)
        send_frame(($urandom_range(3) != 0) ? board.acc_addr : 8'($urandom_range(255)),
                   ($urandom_range(1) != 0) ? board.chan_type : 8'($urandom_range(255)),
                   ($urandom_range(9) == 0) ? 60 : int'($urandom_range(1, 6)),
                   $urandom_range(5) == 0);
      else if (sel < 80) send_item(OP_BYTE, 8'($urandom_range(255)));
      else repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    sys_if.rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.rx_byte = 8'h00;
    board = new();
    board.clear();
    repeat (11) @(posedge clk);
    sys_if.rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_PKT_TIMEOUT, 16'd2);
    write_reg(REG_LINK_DOWN, 16'd4);
    write_reg(REG_ACCEPT_ADDR, 16'hC8);
    write_reg(REG_CHAN_TYPE, 16'h16);
    // directed: good channels frame, link up, bad crc, bad length, timeout flush, link down
    send_frame(8'hC8, 8'h16, 4, 0);
    send_frame(8'hC8, 8'h16, 1, 0);
    send_frame(8'hC8, 8'h21, 2, 1);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h05);
    repeat (6) send_item(OP_TICK, 8'hAA);
    drain();

    write_reg(REG_PASSTHROUGH, 16'd1);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_TICK, 8'h00);
    drain();

    write_reg(REG_PASSTHROUGH, 16'd0);
    write_reg(REG_PKT_TIMEOUT, 16'd0);
    write_reg(REG_LINK_DOWN, 16'd65535);
    write_reg(REG_ACCEPT_ADDR, 16'h00);
    write_reg(REG_CHAN_TYPE, 16'hFF);
    // long receiver stall while items keep coming
    hold_req <= ~hold_req;
    random_phase(8);
    drain();

    write_reg(REG_PKT_TIMEOUT, 16'd3);
    write_reg(REG_LINK_DOWN, 16'd6);
    write_reg(REG_ACCEPT_ADDR, 16'hFF);
    write_reg(REG_CHAN_TYPE, 16'h00);
    send_idle_pct = 74;
    recv_idle_pct = 14;
    random_phase(7);
    drain();

    write_reg(REG_PKT_TIMEOUT, 16'd65535);
    write_reg(REG_LINK_DOWN, 16'd1);
    write_reg(REG_ACCEPT_ADDR, 16'hC8);
    write_reg(REG_CHAN_TYPE, 16'h16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(7);
    drain();

    if (!board.bad && board.pending.size() == 0)
      $display("crsf_frame_receiver_unit test passed");
    else
      $display("crsf_frame_receiver_unit test failed");
    $finish;
  end
endmodule
